// ===== rtl/core/mbet_pkg.sv =====
// ----------------------------------------------------------------------------
// mbet_pkg - shared types and constants for the escape-time core
// Fixed-point widths (signed Q4.28), register indexes and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mbet_pkg;

	// Value format: signed, FRAC_W fraction bits, four integer bits
	localparam int FRAC_W     = 28;
	localparam int VAL_W      = FRAC_W + 4;
	localparam int EXT_W      = VAL_W + 2;   // headroom for sums before clamping
	localparam int HS_W       = 31;          // half_step register width
	localparam int MUL_W      = 31;          // shared multiplier operand width
	localparam int PROD_W     = 2 * MUL_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_RE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_IM = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd5;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [EXT_W-1:0] ext_t;

	localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// 4.0 as an unsigned sum of two squares
	localparam logic [VAL_W-1:0] FOUR = VAL_W'(1) << (FRAC_W + 2);

	// Clamp a widened value into the Q4 range
	function automatic val_t sat_val(input ext_t v);
		val_t r;
		if (v > ext_t'(VAL_MAX)) begin
			r = VAL_MAX;
		end else if (v < ext_t'(VAL_MIN)) begin
			r = VAL_MIN;
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

	// Signed clamp of a magnitude product with a separate sign
	function automatic val_t off_clamp(input logic [PROD_W-1:0] p, input logic neg);
		logic big;
		val_t m;
		big = |p[PROD_W-1:VAL_W-1];
		m   = {1'b0, p[VAL_W-2:0]};
		if (big) begin
			return neg ? VAL_MIN : VAL_MAX;
		end
		return neg ? -m : m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mandelbrot_escape_time_core.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core - Mandelbrot escape count for one pixel
// Sequence: after start is taken, the mapping states MAPX, MAPY and MAPC run,
//   then ITER, SQI, XP and UPD for each iteration until done pulses.
// One item at a time: start is taken only while idle, as the single shared
//   31x31 multiplier serves the mapping and all three products of z^2.
// Results are pulsed for one cycle on done; the receiver cannot stall.
// Reset: async, active low; idle, config registers at their defaults, datapath not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_core #(
	parameter int COORD_BITS = 12,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// item channel
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [COORD_BITS-1:0]            pixel_x,
	input  wire logic [COORD_BITS-1:0]            pixel_y,
	// result channel
	output logic                                  done,
	output logic [COUNT_BITS-1:0]                 escape_count,
	output logic                                  reached_limit,
	// register write channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [mbet_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mbet_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mbet_pkg::*;

	localparam int SIZE_W = COORD_BITS + 1;   // frame size / offset magnitude
	localparam int D_W    = COORD_BITS + 2;   // signed pixel offset 2*pos - size

	localparam logic [SIZE_W-1:0]     WIDTH_RST  = SIZE_W'(640);
	localparam logic [SIZE_W-1:0]     HEIGHT_RST = SIZE_W'(480);
	localparam logic [COUNT_BITS-1:0] LIMIT_RST  = COUNT_BITS'(256);
	localparam logic [HS_W-1:0]       HS_RST     = HS_W'(1048576);

	// Sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAPX = 3'd1;   // |dx| * half_step
	localparam logic [2:0] ST_MAPY = 3'd2;   // c_re out, |dy| * half_step
	localparam logic [2:0] ST_MAPC = 3'd3;   // c_im out
	localparam logic [2:0] ST_ITER = 3'd4;   // limit and |re|, |im| >= 2 checks, re^2
	localparam logic [2:0] ST_SQI  = 3'd5;   // im^2
	localparam logic [2:0] ST_XP   = 3'd6;   // |z|^2 >= 4 check, re*im
	localparam logic [2:0] ST_UPD  = 3'd7;   // z = z^2 + c

	// Configuration registers
	val_t                  center_re_q;
	val_t                  center_im_q;
	logic [HS_W-1:0]       half_step_q;
	logic [SIZE_W-1:0]     width_q;
	logic [SIZE_W-1:0]     height_q;
	logic [COUNT_BITS-1:0] limit_q;

	// Sequencer and working state
	logic [2:0]            state_q;
	logic [COORD_BITS-1:0] pix_x_q;
	logic [COORD_BITS-1:0] pix_y_q;
	val_t                  cr_q;
	val_t                  ci_q;
	val_t                  zr_q;
	val_t                  zi_q;
	logic [FRAC_W:0]       mr_q;       // |re| once known below 2
	logic [FRAC_W:0]       mi_q;
	logic                  neg_q;      // sign of re*im
	logic [MUL_W-1:0]      sr_q;       // floor(re^2)
	logic [MUL_W-1:0]      si_q;       // floor(im^2)
	logic [COUNT_BITS-1:0] count_q;

	// Shared multiplier
	logic [MUL_W-1:0]      mul_a;
	logic [MUL_W-1:0]      mul_b;
	logic [PROD_W-1:0]     prod_q;

	// Result register
	logic                  done_q;
	logic [COUNT_BITS-1:0] escape_count_q;
	logic                  reached_limit_q;

	// Combinational helpers
	logic signed [D_W-1:0] dx;
	logic signed [D_W-1:0] dy;
	logic [SIZE_W-1:0]     dx_mag;
	logic [SIZE_W-1:0]     dy_mag;
	logic [VAL_W-1:0]      mag_r;
	logic [VAL_W-1:0]      mag_i;
	logic                  big_z;
	logic [MUL_W-1:0]      si_now;
	logic [VAL_W-1:0]      sq_sum;
	logic [EXT_W-1:0]      xp_mag;
	ext_t                  xp_val;
	val_t                  zr_next;
	val_t                  zi_next;
	val_t                  map_val;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// ---- Register file ------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_re_q <= '0;
			center_im_q <= '0;
			half_step_q <= HS_RST;
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
			limit_q     <= LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CENTER_RE: center_re_q <= cfg_data[VAL_W-1:0];
				CFG_CENTER_IM: center_im_q <= cfg_data[VAL_W-1:0];
				CFG_HALF_STEP: half_step_q <= cfg_data[HS_W-1:0];
				CFG_WIDTH:     width_q     <= cfg_data[SIZE_W-1:0];
				CFG_HEIGHT:    height_q    <= cfg_data[SIZE_W-1:0];
				CFG_LIMIT:     limit_q     <= cfg_data[COUNT_BITS-1:0];
				default: ;   // unmapped index, write dropped
			endcase
		end
	end

	// ---- Pixel to c mapping -------------------------------------------------
	// Offsets in units of half a pixel pitch; magnitude always fits SIZE_W bits.
	assign dx     = D_W'({1'b0, pix_x_q, 1'b0}) - D_W'({1'b0, width_q});
	assign dy     = D_W'({1'b0, pix_y_q, 1'b0}) - D_W'({1'b0, height_q});
	assign dx_mag = dx[D_W-1] ? SIZE_W'(-dx) : dx[SIZE_W-1:0];
	assign dy_mag = dy[D_W-1] ? SIZE_W'(-dy) : dy[SIZE_W-1:0];

	// The product register holds the offset of whichever axis finished last.
	always_comb begin
		if (state_q == ST_MAPY) begin
			map_val = sat_val(ext_t'(off_clamp(prod_q, dx[D_W-1])) + ext_t'(center_re_q));
		end else begin
			map_val = sat_val(ext_t'(off_clamp(prod_q, dy[D_W-1])) + ext_t'(center_im_q));
		end
	end

	// ---- Iteration datapath -------------------------------------------------
	assign mag_r = zr_q[VAL_W-1] ? VAL_W'(-zr_q) : VAL_W'(zr_q);
	assign mag_i = zi_q[VAL_W-1] ? VAL_W'(-zi_q) : VAL_W'(zi_q);
	// |re| or |im| at or beyond 2.0
	assign big_z = (|mag_r[VAL_W-1:FRAC_W+1]) || (|mag_i[VAL_W-1:FRAC_W+1]);

	// Squares are below 2^(2*FRAC_W+2), so the shifted value fits MUL_W bits.
	assign si_now = prod_q[FRAC_W+MUL_W-1:FRAC_W];
	assign sq_sum = VAL_W'(sr_q) + VAL_W'(si_now);

	// 2*re*im: floor of the product over 2^(FRAC_W-1), sign applied after
	// the magnitude so that dropped bits round towards minus infinity.
	assign xp_mag = {{(EXT_W-VAL_W){1'b0}}, prod_q[FRAC_W+VAL_W-2:FRAC_W-1]}
		+ EXT_W'(|prod_q[FRAC_W-2:0] & neg_q);
	assign xp_val = neg_q ? -ext_t'(xp_mag) : ext_t'(xp_mag);

	assign zi_next = sat_val(xp_val + ext_t'(ci_q));
	assign zr_next = sat_val(ext_t'({{(EXT_W-MUL_W){1'b0}}, sr_q})
		- ext_t'({{(EXT_W-MUL_W){1'b0}}, si_q}) + ext_t'(cr_q));

	// ---- Shared multiplier --------------------------------------------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MAPX: begin
				mul_a = MUL_W'(half_step_q);
				mul_b = MUL_W'(dx_mag);
			end
			ST_MAPY: begin
				mul_a = MUL_W'(half_step_q);
				mul_b = MUL_W'(dy_mag);
			end
			ST_ITER: begin
				mul_a = MUL_W'(mag_r[FRAC_W:0]);
				mul_b = MUL_W'(mag_r[FRAC_W:0]);
			end
			ST_SQI: begin
				mul_a = MUL_W'(mi_q);
				mul_b = MUL_W'(mi_q);
			end
			ST_XP: begin
				mul_a = MUL_W'(mr_q);
				mul_b = MUL_W'(mi_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// ---- Working registers --------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				pix_x_q <= pixel_x;
				pix_y_q <= pixel_y;
				zr_q    <= '0;
				zi_q    <= '0;
			end
			ST_MAPY: cr_q <= map_val;
			ST_MAPC: ci_q <= map_val;
			ST_ITER: begin
				mr_q  <= mag_r[FRAC_W:0];
				mi_q  <= mag_i[FRAC_W:0];
				neg_q <= zr_q[VAL_W-1] ^ zi_q[VAL_W-1];
			end
			ST_SQI: sr_q <= prod_q[FRAC_W+MUL_W-1:FRAC_W];
			ST_XP:  si_q <= si_now;
			ST_UPD: begin
				zr_q <= zr_next;
				zi_q <= zi_next;
			end
			default: ;
		endcase
	end

	// ---- Sequencer ----------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			count_q         <= '0;
			done_q          <= 1'b0;
			escape_count_q  <= '0;
			reached_limit_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						count_q <= '0;
						state_q <= ST_MAPX;
					end
				end
				ST_MAPX: state_q <= ST_MAPY;
				ST_MAPY: state_q <= ST_MAPC;
				ST_MAPC: state_q <= ST_ITER;
				ST_ITER: begin
					// limit reached, or one component already beyond 2
					if ((count_q >= limit_q) || big_z) begin
						done_q          <= 1'b1;
						escape_count_q  <= count_q;
						reached_limit_q <= (count_q == limit_q);
						state_q         <= ST_IDLE;
					end else begin
						state_q <= ST_SQI;
					end
				end
				ST_SQI: state_q <= ST_XP;
				ST_XP: begin
					if (sq_sum >= FOUR) begin
						done_q          <= 1'b1;
						escape_count_q  <= count_q;
						reached_limit_q <= (count_q == limit_q);
						state_q         <= ST_IDLE;
					end else begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					count_q <= count_q + COUNT_BITS'(1);
					state_q <= ST_ITER;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done          = done_q;
	assign escape_count  = escape_count_q;
	assign reached_limit = reached_limit_q;

	// ---- Assertions ---------------------------------------------------------
	// A result only ends a run that was in progress.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a run in progress");

	// The count never passes the limit.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER) |-> (count_q <= limit_q))
		else $error("iteration count beyond limit");

	// The limit flag agrees with the reported count.
	a_limit_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (reached_limit == (escape_count == limit_q)))
		else $error("limit flag disagrees with count");

	// A run that starts leaves idle on the next edge.
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_MAPX))
		else $error("accepted item did not start the run");

endmodule

`default_nettype wire
